// ===== rtl/agd_pkg.sv =====
// Shared definitions for the accelerometer gesture detector.
// Gesture codes, register indexes, reset values and the threshold bundle.
// No dependencies.
`timescale 1ns / 1ps

package agd_pkg;

  // Default hold length of a detected shake, in samples
  localparam int SHAKE_HOLD_DEF = 5;

  // Gesture codes
  localparam logic [2:0] G_NONE  = 3'd0;
  localparam logic [2:0] G_SHAKE = 3'd1;
  localparam logic [2:0] G_FWD   = 3'd2;
  localparam logic [2:0] G_BACK  = 3'd3;
  localparam logic [2:0] G_RIGHT = 3'd4;
  localparam logic [2:0] G_LEFT  = 3'd5;
  localparam logic [2:0] G_DOWN  = 3'd6;
  localparam logic [2:0] G_UP    = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] REG_OFFSET_X   = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd1;
  localparam logic [2:0] REG_OFFSET_Z   = 3'd2;
  localparam logic [2:0] REG_TILT_THR   = 3'd3;
  localparam logic [2:0] REG_FLAT_THR   = 3'd4;
  localparam logic [2:0] REG_SHAKE_THR  = 3'd5;

  // Reset values of the threshold registers
  localparam logic [14:0] TILT_THR_RST  = 15'd500;
  localparam logic [14:0] FLAT_THR_RST  = 15'd200;
  localparam logic [33:0] SHAKE_THR_RST = 34'd1000000;

  // Thresholds used by the classifier
  typedef struct packed {
    logic [14:0] tilt_thr;
    logic [14:0] flat_thr;
  } thr_t;

endpackage

// ===== rtl/agd_classify.sv =====
// Orientation classifier of the accelerometer gesture detector.
// Maps shake flag and corrected sample to a gesture code by priority.
// Depends on agd_pkg.
`timescale 1ns / 1ps

module agd_classify (
  input  logic               shaken,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic signed [15:0] z,
  input  agd_pkg::thr_t      thr,
  output logic [2:0]         gesture
);

  logic signed [16:0] x_ext;
  logic signed [16:0] y_ext;
  logic signed [16:0] tilt_pos;
  logic signed [16:0] tilt_neg;
  logic [15:0]        x_abs;
  logic [15:0]        y_abs;
  logic               flat;

  // Widen to compare against both signs of the tilt threshold
  assign x_ext    = {x[15], x};
  assign y_ext    = {y[15], y};
  assign tilt_pos = $signed({2'b00, thr.tilt_thr});
  assign tilt_neg = -tilt_pos;

  // Magnitudes; -32768 becomes 32768 unsigned
  assign x_abs = x[15] ? 16'(-x) : 16'(x);
  assign y_abs = y[15] ? 16'(-y) : 16'(y);
  assign flat  = (x_abs < {1'b0, thr.flat_thr}) && (y_abs < {1'b0, thr.flat_thr});

  // Priority: shake, tilt x, tilt y, face down, face up
  always_comb begin
    if (shaken) begin
      gesture = agd_pkg::G_SHAKE;
    end else if (x_ext < tilt_neg) begin
      gesture = agd_pkg::G_FWD;
    end else if (x_ext > tilt_pos) begin
      gesture = agd_pkg::G_BACK;
    end else if (y_ext < tilt_neg) begin
      gesture = agd_pkg::G_RIGHT;
    end else if (y_ext > tilt_pos) begin
      gesture = agd_pkg::G_LEFT;
    end else if (flat && !z[15] && (z != 16'sd0)) begin
      gesture = agd_pkg::G_DOWN;
    end else if (flat && z[15]) begin
      gesture = agd_pkg::G_UP;
    end else begin
      gesture = agd_pkg::G_NONE;
    end
  end

endmodule

// ===== rtl/accel_gesture_detector_top.sv =====
// Accelerometer gesture detector, top level.
// Offset correction, shake detection, state and handshakes; uses agd_pkg
// and agd_classify.
`timescale 1ns / 1ps

// One sample enters per cycle while s_axis_tready is high. The first
// register holds the offset-corrected, saturated sample, the second holds
// the result. The loop through the previous sample, shake flag, hold
// counter and last reported gesture closes in the result stage, so each
// sample sees the state left by the one before it. A result waiting on
// m_axis_tready stalls the input only once both registers are full.
// Configuration writes are always ready; write them only while no sample
// is in flight.
module accel_gesture_detector_top #(
  parameter int SHAKE_HOLD = agd_pkg::SHAKE_HOLD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  // Gesture stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // gesture[2:0], gesture_event[3], zero[7:4]
  // Register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [33:0] cfg_data
);

  localparam logic [2:0] HOLD_LAST = 3'(SHAKE_HOLD);

  // Configuration registers
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic signed [15:0] offset_z;
  logic [33:0]        shake_thr;
  agd_pkg::thr_t      thr;

  // Corrected sample stage
  logic               a_valid;
  logic signed [15:0] x_a;
  logic signed [15:0] y_a;
  logic signed [15:0] z_a;
  logic               advance;

  // Detector state
  logic signed [15:0] prev_x;
  logic signed [15:0] prev_y;
  logic signed [15:0] prev_z;
  logic               shaken;
  logic               shaken_next;
  logic [2:0]         hold_count;
  logic [2:0]         hold_count_next;
  logic [2:0]         hold_inc;
  logic [2:0]         last_reported;

  // Shake measure
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [16:0] dz;
  logic [15:0]        adx;
  logic [15:0]        ady;
  logic [15:0]        adz;
  logic [31:0]        sqx;
  logic [31:0]        sqy;
  logic [31:0]        sqz;
  logic [33:0]        sq_sum;
  logic               prev_zero;

  // Result
  logic [2:0]         gesture;
  logic               gesture_event;

  // Add offset and clamp to the signed 16-bit range
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      sat_add = s[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat_add = s[15:0];
    end
  endfunction

  // Write configuration registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x     <= '0;
      offset_y     <= '0;
      offset_z     <= '0;
      thr.tilt_thr <= agd_pkg::TILT_THR_RST;
      thr.flat_thr <= agd_pkg::FLAT_THR_RST;
      shake_thr    <= agd_pkg::SHAKE_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        agd_pkg::REG_OFFSET_X:  offset_x     <= cfg_data[15:0];
        agd_pkg::REG_OFFSET_Y:  offset_y     <= cfg_data[15:0];
        agd_pkg::REG_OFFSET_Z:  offset_z     <= cfg_data[15:0];
        agd_pkg::REG_TILT_THR:  thr.tilt_thr <= cfg_data[14:0];
        agd_pkg::REG_FLAT_THR:  thr.flat_thr <= cfg_data[14:0];
        agd_pkg::REG_SHAKE_THR: shake_thr    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: move stage A into the result whenever the result is free
  assign advance       = a_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !a_valid || advance;

  // Stage A: corrected sample
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      x_a <= sat_add(s_axis_tdata[15:0], offset_x);
      y_a <= sat_add(s_axis_tdata[31:16], offset_y);
      z_a <= sat_add(s_axis_tdata[47:32], offset_z);
    end
  end

  // Advance the hold counter while a shake is held
  assign hold_inc        = hold_count + 3'd1;
  assign hold_count_next = !shaken ? hold_count :
                           (hold_inc == HOLD_LAST) ? 3'd0 : hold_inc;

  // Sum of squared changes against the previous sample
  assign dx  = {x_a[15], x_a} - {prev_x[15], prev_x};
  assign dy  = {y_a[15], y_a} - {prev_y[15], prev_y};
  assign dz  = {z_a[15], z_a} - {prev_z[15], prev_z};
  assign adx = dx[16] ? 16'(-dx) : dx[15:0];
  assign ady = dy[16] ? 16'(-dy) : dy[15:0];
  assign adz = dz[16] ? 16'(-dz) : dz[15:0];
  assign sqx = {16'd0, adx} * {16'd0, adx};
  assign sqy = {16'd0, ady} * {16'd0, ady};
  assign sqz = {16'd0, adz} * {16'd0, adz};
  assign sq_sum = {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};

  // Re-evaluate shake only with a stored sample and no hold running
  assign prev_zero   = (prev_x == 16'sd0) && (prev_y == 16'sd0) && (prev_z == 16'sd0);
  assign shaken_next = (!prev_zero && (hold_count_next == 3'd0)) ?
                       (sq_sum > shake_thr) : shaken;

  agd_classify u_classify (
    .shaken  (shaken_next),
    .x       (x_a),
    .y       (y_a),
    .z       (z_a),
    .thr     (thr),
    .gesture (gesture)
  );

  assign gesture_event = (gesture != agd_pkg::G_NONE) && (gesture != last_reported);

  // Result stage: update state and hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      prev_x        <= '0;
      prev_y        <= '0;
      prev_z        <= '0;
      shaken        <= 1'b0;
      hold_count    <= '0;
      last_reported <= agd_pkg::G_NONE;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
      prev_x        <= x_a;
      prev_y        <= y_a;
      prev_z        <= z_a;
      shaken        <= shaken_next;
      hold_count    <= hold_count_next;
      last_reported <= gesture;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {4'b0000, gesture_event, gesture};
    end
  end

endmodule

// ===== rtl/agd_checker.sv =====
// Port-level checks for the accelerometer gesture detector.
// Bound to accel_gesture_detector_top; depends on agd_pkg.
`timescale 1ns / 1ps

module agd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // An event is only raised for a real gesture
  a_event_gesture: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[2:0] != agd_pkg::G_NONE))
    else $error("event raised with no gesture");

  // Padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'd0))
    else $error("nonzero padding in result");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind accel_gesture_detector_top agd_checker u_agd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb.sv =====
// Testbench for accel_gesture_detector_top: directed table, then randomized
// register settings and sample streams with bursty idling on both streams.
// Depends on agd_pkg and the detector RTL; every result is checked in order.
`timescale 1ns / 1ps

module tb;

  localparam int SHAKE_HOLD   = agd_pkg::SHAKE_HOLD_DEF;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 150;
  localparam int PIPE_SETTLE  = 4;
  localparam int CYCLE_LIMIT  = 200000;

  // Indexes past the register list; writes there must change nothing
  localparam logic [2:0] REG_UNMAPPED_6 = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_7 = 3'd7;

  typedef struct packed {
    logic [2:0] gesture;
    logic       gesture_event;
  } gesture_res_t;

  typedef struct {
    bit                 is_cfg;
    logic [2:0]         idx;
    logic [33:0]        data;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    bit                 typed;
    logic [2:0]         g;
    bit                 ev;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;        // gesture[2:0], gesture_event[3], zero[7:4]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [33:0] cfg_data = '0;

  // Handshake flags seen by the drivers at the falling edge
  bit in_taken  = 1'b0;
  bit cfg_taken = 1'b0;

  // Typed expectation travelling along with the sample being driven
  bit         drv_typed   = 1'b0;
  logic [2:0] drv_gesture = agd_pkg::G_NONE;
  bit         drv_event   = 1'b0;

  bit calm = 1'b0;
  int err_cnt = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_writes = 0;
  int stall_left = 0;

  gesture_res_t gesture_q[$];

  // Shadow of the register file
  logic signed [15:0] cfg_off_x = '0;
  logic signed [15:0] cfg_off_y = '0;
  logic signed [15:0] cfg_off_z = '0;
  logic [14:0]        cfg_tilt  = agd_pkg::TILT_THR_RST;
  logic [14:0]        cfg_flat  = agd_pkg::FLAT_THR_RST;
  logic [33:0]        cfg_shake = agd_pkg::SHAKE_THR_RST;

  // Shadow of the detector state
  int         st_px = 0;
  int         st_py = 0;
  int         st_pz = 0;
  bit         st_shaken = 1'b0;
  logic [2:0] st_hold = '0;
  logic [2:0] st_last = agd_pkg::G_NONE;

  accel_gesture_detector_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned sq_change(input int a, input int b);
    longint unsigned d;
    d = (a >= b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  // Advance the shadow state by one sample and return its gesture
  function automatic gesture_res_t track_gesture(input logic signed [15:0] ax,
                                                 input logic signed [15:0] ay,
                                                 input logic signed [15:0] az);
    int cx, cy, cz, t, f;
    longint unsigned dsum;
    logic [2:0] g;
    gesture_res_t r;
    if (st_shaken) begin
      st_hold = st_hold + 3'd1;
      if (st_hold == SHAKE_HOLD) st_hold = 3'd0;
    end
    cx = clamp16(int'(ax) + int'(cfg_off_x));
    cy = clamp16(int'(ay) + int'(cfg_off_y));
    cz = clamp16(int'(az) + int'(cfg_off_z));
    // A stored all-zero sample skips shake detection
    if (st_px == 0 && st_py == 0 && st_pz == 0) begin
      st_px = cx;
      st_py = cy;
      st_pz = cz;
    end else begin
      dsum = sq_change(cx, st_px) + sq_change(cy, st_py) + sq_change(cz, st_pz);
      st_px = cx;
      st_py = cy;
      st_pz = cz;
      if (st_hold == 3'd0) st_shaken = (dsum > cfg_shake);
    end
    t = int'(cfg_tilt);
    f = int'(cfg_flat);
    if (st_shaken) g = agd_pkg::G_SHAKE;
    else if (cx < -t) g = agd_pkg::G_FWD;
    else if (cx > t) g = agd_pkg::G_BACK;
    else if (cy < -t) g = agd_pkg::G_RIGHT;
    else if (cy > t) g = agd_pkg::G_LEFT;
    else if (cx < f && -cx < f && cy < f && -cy < f && cz > 0) g = agd_pkg::G_DOWN;
    else if (cx < f && -cx < f && cy < f && -cy < f && cz < 0) g = agd_pkg::G_UP;
    else g = agd_pkg::G_NONE;
    r.gesture = g;
    r.gesture_event = (g != agd_pkg::G_NONE && g != st_last);
    st_last = g;
    return r;
  endfunction

  function automatic stim_row_t sample_row(input int x, input int y, input int z,
                                           input bit typed = 1'b0,
                                           input logic [2:0] g = agd_pkg::G_NONE,
                                           input bit ev = 1'b0);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.idx = '0;
    r.data = '0;
    r.x = x[15:0];
    r.y = y[15:0];
    r.z = z[15:0];
    r.typed = typed;
    r.g = g;
    r.ev = ev;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [2:0] idx, input logic [33:0] d);
    stim_row_t r;
    r = sample_row(0, 0, 0);
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = d;
    return r;
  endfunction

  // Drive one sample transaction, with an optional idle burst ahead of it
  task automatic send_sample(input stim_row_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.z, r.y, r.x};
    drv_typed     <= r.typed;
    drv_gesture   <= r.g;
    drv_event     <= r.ev;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
    n_samples++;
  endtask

  // Hold one register write until its transaction completes; valid stays up
  task automatic write_reg(input logic [2:0] idx, input logic [33:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
    n_writes++;
  endtask

  // Stop input and let the pipeline empty
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (gesture_q.size() != 0) @(negedge clk);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  // Result stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: check results, predict accepted samples, track register writes
  always @(posedge clk) begin
    gesture_res_t want, pred;
    in_taken  <= s_axis_tvalid && s_axis_tready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (gesture_q.size() == 0) begin
          $error("unexpected result transaction: gesture %0d", m_axis_tdata[2:0]);
          err_cnt++;
        end else begin
          want = gesture_q.pop_front();
          if (m_axis_tdata[2:0] !== want.gesture) begin
            $error("gesture: expected %0d, got %0d", want.gesture, m_axis_tdata[2:0]);
            err_cnt++;
          end
          if (m_axis_tdata[3] !== want.gesture_event) begin
            $error("gesture_event: expected %0d, got %0d", want.gesture_event,
                   m_axis_tdata[3]);
            err_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = track_gesture(s_axis_tdata[15:0], s_axis_tdata[31:16],
                             s_axis_tdata[47:32]);
        if (drv_typed) begin
          pred.gesture = drv_gesture;
          pred.gesture_event = drv_event;
        end
        gesture_q.push_back(pred);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          agd_pkg::REG_OFFSET_X:  cfg_off_x = cfg_data[15:0];
          agd_pkg::REG_OFFSET_Y:  cfg_off_y = cfg_data[15:0];
          agd_pkg::REG_OFFSET_Z:  cfg_off_z = cfg_data[15:0];
          agd_pkg::REG_TILT_THR:  cfg_tilt  = cfg_data[14:0];
          agd_pkg::REG_FLAT_THR:  cfg_flat  = cfg_data[14:0];
          agd_pkg::REG_SHAKE_THR: cfg_shake = cfg_data;
          default: ;
        endcase
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    stim_row_t dir_tab[$];
    stim_row_t row;
    int ph, k, mode, bx, by, bz, rx, ry, rz;
    int v_offx, v_offy, v_offz, v_tilt, v_flat;
    logic [33:0] v_shake;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table, reset register values
    dir_tab.push_back(sample_row(0, 0, 1000, 1'b1, agd_pkg::G_DOWN, 1'b1));
    dir_tab.push_back(sample_row(0, 0, 1000, 1'b1, agd_pkg::G_DOWN, 1'b0));
    dir_tab.push_back(sample_row(0, 0, -1000, 1'b1, agd_pkg::G_SHAKE, 1'b1));
    // Shake hold, then release into screen up
    repeat (5) dir_tab.push_back(sample_row(0, 0, -1000));
    // Tilt classes and threshold boundaries
    dir_tab.push_back(sample_row(-501, 0, -1000));
    dir_tab.push_back(sample_row(-500, 0, -1000));
    dir_tab.push_back(sample_row(-300, 0, -1000));
    dir_tab.push_back(sample_row(200, 0, -1000));
    dir_tab.push_back(sample_row(501, 0, -1000));
    dir_tab.push_back(sample_row(0, -501, -1000));
    dir_tab.push_back(sample_row(0, 0, -1000));
    dir_tab.push_back(sample_row(0, 501, -1000));
    dir_tab.push_back(sample_row(100, 0, -400));
    // Flat with z at zero, then a stored zero sample
    dir_tab.push_back(sample_row(199, -199, 0));
    dir_tab.push_back(sample_row(0, 0, 0));
    dir_tab.push_back(sample_row(32767, 32767, 32767, 1'b1, agd_pkg::G_BACK, 1'b1));
    dir_tab.push_back(sample_row(-32768, -32768, -32768, 1'b1, agd_pkg::G_SHAKE, 1'b1));
    // Saturating sums on both sides
    dir_tab.push_back(reg_row(agd_pkg::REG_OFFSET_X, 34'h3_FFFF_7FFF));
    dir_tab.push_back(reg_row(agd_pkg::REG_OFFSET_Y, 34'h0_0000_8000));
    dir_tab.push_back(sample_row(32767, -32768, 0));
    dir_tab.push_back(sample_row(100, -100, 5));
    dir_tab.push_back(reg_row(agd_pkg::REG_OFFSET_X, 34'd0));
    dir_tab.push_back(reg_row(agd_pkg::REG_OFFSET_Y, 34'd0));
    dir_tab.push_back(reg_row(REG_UNMAPPED_6, 34'h3_FFFF_FFFF));
    dir_tab.push_back(sample_row(0, 0, 1000));

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        wait_for_results();
        write_reg(row.idx, row.data);
        cfg_valid <= 1'b0;
      end else begin
        send_sample(row);
      end
    end

    // Random phases, each under its own register setting
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_for_results();
      calm = (ph == NUM_PHASES - 1);
      case (ph)
        0: begin
          v_offx = 0; v_offy = 0; v_offz = 0;
          v_tilt = 500; v_flat = 200; v_shake = 34'd1000000;
        end
        1: begin
          v_offx = 32767; v_offy = 32767; v_offz = 32767;
          v_tilt = 0; v_flat = 0; v_shake = 34'd0;
        end
        2: begin
          v_offx = -32768; v_offy = -32768; v_offz = -32768;
          v_tilt = 32767; v_flat = 32767; v_shake = 34'h3_FFFF_FFFF;
        end
        default: begin
          v_offx = int'($urandom_range(0, 4000)) - 2000;
          v_offy = int'($urandom_range(0, 4000)) - 2000;
          v_offz = int'($urandom_range(0, 4000)) - 2000;
          v_tilt = $urandom_range(100, 2500);
          v_flat = $urandom_range(0, 1500);
          v_shake = 34'($urandom_range(20000, 5000000));
        end
      endcase
      // Junk above each register's width must be ignored
      write_reg(agd_pkg::REG_OFFSET_X, {18'($urandom), v_offx[15:0]});
      write_reg(agd_pkg::REG_OFFSET_Y, {18'($urandom), v_offy[15:0]});
      write_reg(agd_pkg::REG_OFFSET_Z, {18'($urandom), v_offz[15:0]});
      write_reg(agd_pkg::REG_TILT_THR, {19'($urandom), v_tilt[14:0]});
      write_reg(agd_pkg::REG_FLAT_THR, {19'($urandom), v_flat[14:0]});
      write_reg(agd_pkg::REG_SHAKE_THR, v_shake);
      write_reg(REG_UNMAPPED_6, {2'($urandom), 32'($urandom)});
      write_reg(REG_UNMAPPED_7, {2'($urandom), 32'($urandom)});
      cfg_valid <= 1'b0;

      bx = 0; by = 0; bz = 1000;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        mode = $urandom_range(0, 19);
        if (mode < 12) begin
          // Hold orientation with small jitter
          rx = clamp16(bx - v_offx + int'($urandom_range(0, 600)) - 300);
          ry = clamp16(by - v_offy + int'($urandom_range(0, 600)) - 300);
          rz = clamp16(bz - v_offz + int'($urandom_range(0, 600)) - 300);
        end else if (mode < 15) begin
          // Move to a new orientation: flat face or a tilt
          if ($urandom_range(0, 2) == 0) begin
            bx = int'($urandom_range(0, 300)) - 150;
            by = int'($urandom_range(0, 300)) - 150;
            bz = $urandom_range(0, 1) ? 1000 : -1000;
          end else begin
            bx = int'($urandom_range(0, 3000)) - 1500;
            by = int'($urandom_range(0, 3000)) - 1500;
            bz = int'($urandom_range(0, 2000)) - 1000;
          end
          rx = clamp16(bx - v_offx);
          ry = clamp16(by - v_offy);
          rz = clamp16(bz - v_offz);
        end else if (mode < 17) begin
          // Violent jolt
          rx = clamp16(bx - v_offx + int'($urandom_range(0, 8000)) - 4000);
          ry = clamp16(by - v_offy + int'($urandom_range(0, 8000)) - 4000);
          rz = clamp16(bz - v_offz + int'($urandom_range(0, 8000)) - 4000);
        end else if (mode == 17) begin
          // Corrected sample of zero
          rx = clamp16(-v_offx);
          ry = clamp16(-v_offy);
          rz = clamp16(-v_offz);
        end else begin
          rx = int'($urandom_range(0, 65535)) - 32768;
          ry = int'($urandom_range(0, 65535)) - 32768;
          rz = int'($urandom_range(0, 65535)) - 32768;
        end
        send_sample(sample_row(rx, ry, rz));
      end
    end

    wait_for_results();
    if (gesture_q.size() != 0) begin
      $error("%0d expected results never arrived", gesture_q.size());
      err_cnt++;
    end
    $display("Summary: %0d samples sent, %0d results checked, %0d register writes",
             n_samples, n_results, n_writes);
    $display("Covered the directed table and %0d randomized register settings",
             NUM_PHASES);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
